>>> rtl/priority_order_with_day_rotation_defines.svh
// Assertion macros for the checker bound to the ordering block.
`ifndef PRIORITY_ORDER_WITH_DAY_ROTATION_DEFINES_SVH
`define PRIORITY_ORDER_WITH_DAY_ROTATION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PODR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PODR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/podr_pkg.sv
`default_nettype none

package podr_pkg;

    localparam int ZONE_W     = 3;
    localparam int SEC_W      = 16;
    localparam int DAY_W      = 32;
    localparam int PRIO_W     = 8;
    localparam int CFG_W      = 64;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 24;
    localparam int DIV_CNT_W  = 5;

    typedef struct packed {
        logic [SEC_W-1:0]  seconds;
        logic [ZONE_W-1:0] zone;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic [PRIO_W-1:0] prio_of(input logic [CFG_W-1:0] prios,
                                                  input logic [ZONE_W-1:0] zone);
        return prios[{zone, 3'b000} +: PRIO_W];
    endfunction

endpackage

`default_nettype wire

>>> rtl/priority_order_with_day_rotation.sv
// Orders a list of watering entries by zone priority and rotates each run of
// equal priority by the day number.
// Input channel (s_*): one entry per transfer; tdata carries zone, seconds and
// day, tlast marks the final entry of the list, whose day is used. Entries
// past MAX_ENTRIES are dropped. Output channel (m_*): one transfer per held
// entry in order, tlast on the final one. cfg_wr_en writes the eight 8-bit
// zone priorities (zone z in bits 8z+7..8z), to be done only while idle.
// Entries load back to back. After the final entry the list is sorted in
// place by one compare unit over an entry memory with one read and one write
// port: each entry is captured as the key, each earlier entry that orders
// after it moves up one position, and the key goes into the gap. Each run of
// equal priority is found by scanning from its first entry, its day remainder
// is formed one bit per cycle through a single subtractor, and each result is
// read and loaded into the output register. A new list is accepted once the
// final result has been loaded into the output register. A stalled receiver
// holds the output register and halts the sequencer ahead of the next result.
// Reset empties the list, clears the priorities and drops any pending result.
module priority_order_with_day_rotation
    import podr_pkg::*;
#(
    parameter int MAX_ENTRIES = 8
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    cfg_wr_en,
    input  wire  [CFG_W-1:0]       cfg_wr_data,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    // s_tdata: zone [2:0], seconds [18:3], day [50:19], zeros [55:51]
    input  wire  [S_TDATA_W-1:0]   s_tdata,
    input  wire                    s_tlast,
    output logic                   m_tvalid,
    input  wire                    m_tready,
    // m_tdata: out_zone [2:0], out_seconds [18:3], zeros [23:19]
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic                   m_tlast
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    localparam logic [3:0] ST_LOAD      = 4'd0;
    localparam logic [3:0] ST_KEY_RD    = 4'd1;
    localparam logic [3:0] ST_KEY_CAP   = 4'd2;
    localparam logic [3:0] ST_CMP_RD    = 4'd3;
    localparam logic [3:0] ST_CMP       = 4'd4;
    localparam logic [3:0] ST_RUN_START = 4'd5;
    localparam logic [3:0] ST_RUN_PRIO  = 4'd6;
    localparam logic [3:0] ST_RUN_SCAN  = 4'd7;
    localparam logic [3:0] ST_DIV       = 4'd8;
    localparam logic [3:0] ST_EMIT_RD   = 4'd9;
    localparam logic [3:0] ST_EMIT_WR   = 4'd10;

    entry_t mem [MAX_ENTRIES];

    logic [3:0]           state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        i_reg, i_next;
    logic [CW-1:0]        j_reg, j_next;
    entry_t               key_reg, key_next;
    logic [CW-1:0]        start_reg, start_next;
    logic [CW-1:0]        end_reg, end_next;
    logic [CW-1:0]        p_reg, p_next;
    logic [CW-1:0]        out_idx_reg, out_idx_next;
    logic [PRIO_W-1:0]    run_prio_reg, run_prio_next;
    logic [DAY_W-1:0]     abs_day_reg, abs_day_next;
    logic                 day_neg_reg, day_neg_next;
    logic [DAY_W-1:0]     div_sh_reg, div_sh_next;
    logic [CW-1:0]        rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [CFG_W-1:0]     prio_reg;
    logic                 m_tvalid_reg, m_tvalid_next;
    entry_t               m_data_reg, m_data_next;
    logic                 m_tlast_reg, m_tlast_next;
    entry_t               rd_data_reg;

    logic [AW-1:0]        rd_addr;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    entry_t               mem_wdata;

    logic                 s_accept;
    logic                 out_free;
    logic [DAY_W-1:0]     in_day;
    logic [CW-1:0]        j_dec;
    logic [CW-1:0]        i_inc;
    logic [CW-1:0]        end_inc;
    logic [CW-1:0]        p_inc;
    logic [CW-1:0]        out_idx_inc;
    logic [PRIO_W-1:0]    rd_prio;
    logic                 goes_after;
    logic [CW-1:0]        run_len;
    logic [CW:0]          trial;
    logic [CW:0]          trial_sub;
    logic [CW-1:0]        rem_new;
    logic [CW-1:0]        shift;

    assign s_tready = (state_reg == ST_LOAD);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign in_day   = s_tdata[50:19];

    assign j_dec       = j_reg - 1'b1;
    assign i_inc       = i_reg + 1'b1;
    assign end_inc     = end_reg + 1'b1;
    assign p_inc       = p_reg + 1'b1;
    assign out_idx_inc = out_idx_reg + 1'b1;

    assign rd_prio    = prio_of(prio_reg, rd_data_reg.zone);
    // The shared compare: ordering key is priority first, zone second.
    assign goes_after = {rd_prio, rd_data_reg.zone} > {prio_of(prio_reg, key_reg.zone), key_reg.zone};

    // Restoring remainder step of |day| by the run length.
    assign run_len   = end_reg - start_reg;
    assign trial     = {rem_reg, div_sh_reg[DAY_W-1]};
    assign trial_sub = trial - {1'b0, run_len};
    assign rem_new   = (trial >= {1'b0, run_len}) ? trial_sub[CW-1:0] : trial[CW-1:0];
    assign shift     = (day_neg_reg && rem_new != '0) ? run_len - rem_new : rem_new;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        key_next      = key_reg;
        start_next    = start_reg;
        end_next      = end_reg;
        p_next        = p_reg;
        out_idx_next  = out_idx_reg;
        run_prio_next = run_prio_reg;
        abs_day_next  = abs_day_reg;
        day_neg_next  = day_neg_reg;
        div_sh_next   = div_sh_reg;
        rem_next      = rem_reg;
        div_cnt_next  = div_cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_tlast_next  = m_tlast_reg;
        rd_addr       = '0;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = key_reg;

        case (state_reg)
            ST_LOAD: begin
                out_idx_next = '0;
                start_next   = '0;
                end_next     = {{(CW-1){1'b0}}, 1'b1};
                i_next       = {{(CW-1){1'b0}}, 1'b1};
                if (s_accept) begin
                    if (count_reg < MAX_CNT) begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[AW-1:0];
                        mem_wdata  = entry_t'(s_tdata[ENTRY_W-1:0]);
                        count_next = count_reg + 1'b1;
                    end
                    if (s_tlast) begin
                        day_neg_next = in_day[DAY_W-1];
                        abs_day_next = in_day[DAY_W-1] ? (~in_day + 1'b1) : in_day;
                        if (count_next == {{(CW-1){1'b0}}, 1'b1}) begin
                            state_next = ST_RUN_START;
                        end else begin
                            state_next = ST_KEY_RD;
                        end
                    end
                end
            end
            ST_KEY_RD: begin
                rd_addr    = i_reg[AW-1:0];
                state_next = ST_KEY_CAP;
            end
            ST_KEY_CAP: begin
                key_next   = rd_data_reg;
                j_next     = i_reg;
                state_next = ST_CMP_RD;
            end
            ST_CMP_RD: begin
                if (j_reg == '0) begin
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = key_reg;
                    i_next    = i_inc;
                    state_next = (i_inc == count_reg) ? ST_RUN_START : ST_KEY_RD;
                end else begin
                    rd_addr    = j_dec[AW-1:0];
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                mem_we    = 1'b1;
                mem_waddr = j_reg[AW-1:0];
                if (goes_after) begin
                    mem_wdata  = rd_data_reg;
                    j_next     = j_dec;
                    state_next = ST_CMP_RD;
                end else begin
                    mem_wdata  = key_reg;
                    i_next     = i_inc;
                    state_next = (i_inc == count_reg) ? ST_RUN_START : ST_KEY_RD;
                end
            end
            ST_RUN_START: begin
                rd_addr    = start_reg[AW-1:0];
                state_next = ST_RUN_PRIO;
            end
            ST_RUN_PRIO: begin
                run_prio_next = rd_prio;
                div_sh_next   = abs_day_reg;
                rem_next      = '0;
                div_cnt_next  = '0;
                if (end_reg == count_reg) begin
                    state_next = ST_DIV;
                end else begin
                    rd_addr    = end_reg[AW-1:0];
                    state_next = ST_RUN_SCAN;
                end
            end
            ST_RUN_SCAN: begin
                if (rd_prio == run_prio_reg) begin
                    end_next = end_inc;
                    if (end_inc == count_reg) begin
                        state_next = ST_DIV;
                    end else begin
                        rd_addr = end_inc[AW-1:0];
                    end
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                div_sh_next  = {div_sh_reg[DAY_W-2:0], 1'b0};
                rem_next     = rem_new;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == '1) begin
                    p_next     = start_reg + shift;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                rd_addr    = p_reg[AW-1:0];
                state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                rd_addr = p_reg[AW-1:0];
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = rd_data_reg;
                    m_tlast_next  = (out_idx_inc == count_reg);
                    out_idx_next  = out_idx_inc;
                    p_next        = (p_inc == end_reg) ? start_reg : p_inc;
                    if (out_idx_inc == end_reg) begin
                        if (end_reg == count_reg) begin
                            count_next = '0;
                            state_next = ST_LOAD;
                        end else begin
                            start_next = end_reg;
                            end_next   = end_inc;
                            state_next = ST_RUN_START;
                        end
                    end else begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            prio_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                prio_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        key_reg      <= key_next;
        start_reg    <= start_next;
        end_reg      <= end_next;
        p_reg        <= p_next;
        out_idx_reg  <= out_idx_next;
        run_prio_reg <= run_prio_next;
        abs_day_reg  <= abs_day_next;
        day_neg_reg  <= day_neg_next;
        div_sh_reg   <= div_sh_next;
        rem_reg      <= rem_next;
        div_cnt_reg  <= div_cnt_next;
        m_data_reg   <= m_data_next;
        m_tlast_reg  <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-ENTRY_W){1'b0}}, m_data_reg};
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

>>> rtl/podr_check.sv
`default_nettype none

`include "priority_order_with_day_rotation_defines.svh"

module podr_check
    import podr_pkg::*;
(
    input wire                  aclk,
    input wire                  aresetn,
    input wire                  s_tvalid,
    input wire                  s_tready,
    input wire                  s_tlast,
    input wire                  m_tvalid,
    input wire                  m_tready,
    input wire [M_TDATA_W-1:0]  m_tdata,
    input wire                  m_tlast
);

    // A pending result that is not the final one means the list is still being worked off.
    `PODR_ASSERT_NOW(a_no_load_mid_list, m_tvalid && !m_tlast, !s_tready, "input taken while a list is still being emitted")

    // The final entry of a list starts the ordering, which closes the input.
    `PODR_ASSERT_NEXT(a_close_after_last, s_tvalid && s_tready && s_tlast, !s_tready, "input still open after the final entry")

    // Entries before the final one only fill the list.
    `PODR_ASSERT_NEXT(a_open_while_filling, s_tvalid && s_tready && !s_tlast, s_tready && !(m_tvalid && !m_tlast), "list loading interrupted")

    // A stalled result holds its payload.
    `PODR_ASSERT_NEXT(a_hold_on_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

endmodule

bind priority_order_with_day_rotation podr_check u_podr_check (.*);

`default_nettype wire
